// ----- sv/gn3_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gn3_pkg
// Shared constants, register indexes and the permutation ROM of the 3D
// gradient noise block.
// ----------------------------------------------------------------------------
package gn3_pkg;

   localparam int GN3_FRAC_BITS   = 16;
   localparam int GN3_MAX_OCTAVES = 16;

   // integer bits kept in every coordinate word
   localparam int INT_BITS = 16;

   // octave amplitude, Q8.16, starts at 128.0
   localparam int               AMP_W     = 24;
   localparam logic [AMP_W-1:0] AMP_START = 24'h800000;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_DATA_W-1:0] PERS_ONE = 17'h10000;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_NOISE_MODE    = 2'd0,
      CSR_REPEAT_PERIOD = 2'd1,
      CSR_OCTAVE_COUNT  = 2'd2,
      CSR_PERSISTENCE   = 2'd3
   } csr_index_type;

   localparam logic [7:0] PERM_ROM [256] = '{
      8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
      8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
      8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
      8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
      8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
      8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
      8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
      8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
      8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
      8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
      8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
      8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
      8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
      8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
      8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
      8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
      8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
      8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
      8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
      8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
      8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
      8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
      8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
      8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
      8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
      8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
      8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
      8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
      8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
      8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
      8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
      8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
   };

endpackage
`default_nettype wire

// ----- sv/gradient_noise_3d.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gradient_noise_3d
// Improved 3D gradient noise with an optional normalized octave sum.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one point per transaction (three unsigned Q16.16 coords),
//   rsp_* returns one Q0.16 noise value per point, in request order.
//   csr_* writes the mode, repeat period, octave count and persistence; write
//   only while no transaction is in flight.
// Single mode: the datapath is a stall-on-output pipeline that takes a new
//   point every cycle. It has 27 register stages: the input register, 16
//   stages of the per-digit modulo by the repeat period, 3 hash stages of the
//   permutation ROM, the gradient stage, 3 lerp stages, clamp, weighting and
//   the response register.
// Octave mode: the point is held and reissued once per octave, one octave per
//   cycle while the output does not stall, through the same pipeline; the
//   weighted sum is then divided by the amplitude sum in a bit-serial divider.
//   The next point is accepted once the response of the last one is loaded.
// Reset: registers return to mode 0, period 1, one octave, persistence 0.5;
//   all valid bits clear. When rsp_tready is low with a response pending, the
//   whole pipeline holds; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module gradient_noise_3d
   import gn3_pkg::*;
#(
   parameter int FRAC_BITS   = GN3_FRAC_BITS,
   parameter int MAX_OCTAVES = GN3_MAX_OCTAVES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [95:0]           req_tdata,   // x_coord, y_coord, z_coord
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata    // noise_value
);

   localparam int CW        = INT_BITS + FRAC_BITS;   // coordinate word
   localparam int GW        = FRAC_BITS + 3;          // signed gradient / lerp
   localparam int NW        = FRAC_BITS + 1;          // fade and noise
   localparam int QW        = 2 * FRAC_BITS + 4;      // fade polynomial
   localparam int MOD_STEPS = INT_BITS;
   localparam int CNT_W     = $clog2(MAX_OCTAVES + 1);
   localparam int SH_W      = CNT_W + 1;
   localparam int SUM_W     = AMP_W + CNT_W;
   localparam int TOT_W     = SUM_W + NW;
   localparam int DC_W      = $clog2(NW);

   localparam logic signed [GW-1:0] FX_ONE = GW'(1 << FRAC_BITS);
   localparam logic signed [GW-1:0] FX_TWO = GW'(2 << FRAC_BITS);

   typedef struct packed {
      logic             valid;
      logic             oct;
      logic             last;
      logic [AMP_W-1:0] amp;
   } tag_type;

   typedef struct packed {
      tag_type                      tag;
      logic [2:0][INT_BITS-1:0]     ci;
      logic [2:0][FRAC_BITS-1:0]    fr;
   } mod_stage_type;

   // -------------------------------------------------------------------------
   // Helpers
   // -------------------------------------------------------------------------
   function automatic logic [INT_BITS-1:0] mod_step(input logic [INT_BITS-1:0] r,
                                                    input logic [INT_BITS-1:0] p,
                                                    input int b);
      logic [2*INT_BITS-1:0] d;
      d = {{INT_BITS{1'b0}}, p} << b;
      if (p != '0 && {{INT_BITS{1'b0}}, r} >= d) begin
         mod_step = r - d[INT_BITS-1:0];
      end else begin
         mod_step = r;
      end
   endfunction

   function automatic logic [7:0] next_cell(input logic [7:0] c,
                                            input logic [INT_BITS-1:0] p);
      logic [INT_BITS-1:0] inc;
      inc = INT_BITS'(c) + 1'b1;
      if (p != '0 && inc == p) begin
         next_cell = '0;
      end else begin
         next_cell = inc[7:0];
      end
   endfunction

   function automatic logic signed [GW-1:0] grad(input logic [7:0] hv,
                                                 input logic signed [GW-1:0] x,
                                                 input logic signed [GW-1:0] y,
                                                 input logic signed [GW-1:0] z);
      logic [3:0]              h;
      logic signed [GW-1:0]    gu;
      logic signed [GW-1:0]    gv;
      h  = hv[3:0];
      gu = (h < 4'd8) ? x : y;
      if (h < 4'd4) begin
         gv = y;
      end else if (h inside {4'd12, 4'd14}) begin
         gv = x;
      end else begin
         gv = z;
      end
      grad = (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
   endfunction

   function automatic logic signed [GW-1:0] lerp(input logic signed [GW-1:0] a,
                                                 input logic signed [GW-1:0] b,
                                                 input logic [NW-1:0] w);
      logic signed [GW:0]       d;
      logic signed [GW+NW+1:0]  p;
      d    = {b[GW-1], b} - {a[GW-1], a};
      p    = d * $signed({1'b0, w});
      lerp = a + GW'(p >>> FRAC_BITS);
   endfunction

   function automatic logic [15:0] to_q16(input logic [NW-1:0] r);
      logic [NW+15:0] s;
      s = {r, 16'h0000} >> FRAC_BITS;
      if (s > (NW+16)'(16'hFFFF)) begin
         to_q16 = 16'hFFFF;
      end else begin
         to_q16 = s[15:0];
      end
   endfunction

   // -------------------------------------------------------------------------
   // Configuration registers
   // -------------------------------------------------------------------------
   logic                  mode_ff;
   logic [INT_BITS-1:0]   period_ff;
   logic [4:0]            count_ff;
   logic [CSR_DATA_W-1:0] pers_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         period_ff <= INT_BITS'(1);
         count_ff  <= 5'd1;
         pers_ff   <= 17'd32768;
      end else if (csr_wen) begin
         case (csr_addr)
            CSR_NOISE_MODE:    mode_ff   <= csr_wdata[0];
            CSR_REPEAT_PERIOD: period_ff <= csr_wdata[INT_BITS-1:0];
            CSR_OCTAVE_COUNT:  count_ff  <= csr_wdata[4:0];
            CSR_PERSISTENCE:   pers_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // Handshake and octave issue
   // -------------------------------------------------------------------------
   logic                 rsp_tvalid_ff;
   logic [15:0]          rsp_tdata_ff;
   logic                 adv;
   logic                 accept;
   logic                 oct_busy_ff;
   logic                 issue_ff;
   logic [31:0]          ox_ff, oy_ff, oz_ff;
   logic [CNT_W-1:0]     idx_ff, n_ff;
   logic [AMP_W-1:0]     amp_ff;
   logic [CSR_DATA_W-1:0] pm_ff;
   logic [SUM_W-1:0]     amp_sum_ff;
   logic                 issue_last;
   logic [SH_W-1:0]      sh;
   logic [AMP_W+CSR_DATA_W-1:0] amp_prod;
   logic                 div_busy_ff;
   logic                 div_done_ff;

   // the whole pipeline advances when the response register is free
   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv && !oct_busy_ff;
   assign accept     = req_tvalid && req_tready;
   assign issue_last = (CNT_W'(idx_ff + 1'b1) == n_ff);
   assign sh         = SH_W'(idx_ff) + SH_W'(2);
   assign amp_prod   = amp_ff * pm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         oct_busy_ff <= 1'b0;
         issue_ff    <= 1'b0;
      end else begin
         if (accept && mode_ff) begin
            // hold the point and reissue it once per octave
            oct_busy_ff <= 1'b1;
            issue_ff    <= 1'b1;
            ox_ff       <= req_tdata[31:0];
            oy_ff       <= req_tdata[63:32];
            oz_ff       <= req_tdata[95:64];
            idx_ff      <= '0;
            if (count_ff == 5'd0) begin
               n_ff <= CNT_W'(1);
            end else if (int'(count_ff) > MAX_OCTAVES) begin
               n_ff <= CNT_W'(MAX_OCTAVES);
            end else begin
               n_ff <= CNT_W'(count_ff);
            end
            pm_ff      <= (pers_ff > PERS_ONE) ? PERS_ONE : pers_ff;
            amp_ff     <= AMP_START;
            amp_sum_ff <= '0;
         end else if (issue_ff && adv) begin
            amp_sum_ff <= amp_sum_ff + SUM_W'(amp_ff);
            amp_ff     <= amp_prod[AMP_W+15:16];
            idx_ff     <= CNT_W'(idx_ff + 1'b1);
            if (issue_last) begin
               issue_ff <= 1'b0;
            end
         end
         if (div_done_ff && adv) begin
            oct_busy_ff <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Wrap stages: integer parts reduced modulo the repeat period, one
   // quotient bit per stage
   // -------------------------------------------------------------------------
   mod_stage_type      mod_ff [MOD_STEPS+1];
   logic [2:0][CW-1:0] in_coord;

   always_comb begin
      if (issue_ff) begin
         in_coord[0] = CW'(ox_ff) << sh;
         in_coord[1] = CW'(oy_ff) << sh;
         in_coord[2] = CW'(oz_ff) << sh;
      end else begin
         in_coord[0] = CW'(req_tdata[31:0]);
         in_coord[1] = CW'(req_tdata[63:32]);
         in_coord[2] = CW'(req_tdata[95:64]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= MOD_STEPS; j++) begin
            mod_ff[j].tag.valid <= 1'b0;
         end
      end else if (adv) begin
         mod_ff[0].tag.valid <= (accept && !mode_ff) || issue_ff;
         mod_ff[0].tag.oct   <= issue_ff;
         mod_ff[0].tag.last  <= issue_ff && issue_last;
         mod_ff[0].tag.amp   <= amp_ff;
         for (int k = 0; k < 3; k++) begin
            mod_ff[0].ci[k] <= in_coord[k][CW-1:FRAC_BITS];
            mod_ff[0].fr[k] <= in_coord[k][FRAC_BITS-1:0];
         end
         for (int j = 0; j < MOD_STEPS; j++) begin
            mod_ff[j+1].tag <= mod_ff[j].tag;
            mod_ff[j+1].fr  <= mod_ff[j].fr;
            for (int k = 0; k < 3; k++) begin
               mod_ff[j+1].ci[k] <= mod_step(mod_ff[j].ci[k], period_ff,
                                             MOD_STEPS - 1 - j);
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Hash, fade, gradient, lerp, clamp and weighting stages
   // -------------------------------------------------------------------------
   mod_stage_type mo;
   assign mo = mod_ff[MOD_STEPS];

   tag_type                    tag_ff [1:9];
   logic [7:0]                 ha_ff [2];
   logic [7:0]                 hb_ff [4];
   logic [7:0]                 hc_ff [8];
   logic [7:0]                 yi1_ff, yn1_ff, zi1_ff, zn1_ff, zi2_ff, zn2_ff;
   logic [2:0][FRAC_BITS-1:0]  t1_ff, t2_ff, t3_ff;
   logic [2*FRAC_BITS-1:0]     tt_ff [3];
   logic [FRAC_BITS-1:0]       sq_ff [3];
   logic [QW-1:0]              q_ff [3];
   logic [FRAC_BITS-1:0]       cube_ff [3];
   logic [FRAC_BITS+3:0]       qs_ff [3];
   logic [NW-1:0]              fade_ff [3];
   logic [NW-1:0]              v5_ff, w5_ff, w6_ff;
   logic signed [GW-1:0]       g_ff [8];
   logic signed [GW-1:0]       l1_ff [4];
   logic signed [GW-1:0]       l2_ff [2];
   logic signed [GW-1:0]       l3_ff;
   logic [NW-1:0]              noise_ff, noise9_ff;
   logic [NW+AMP_W-1:0]        prod_ff;
   logic [7:0]                 xn;
   logic signed [GW-1:0]       r8;
   logic signed [GW-1:0]       off [3][2];
   logic [2*FRAC_BITS-1:0]     cube_full [3];
   logic [2*FRAC_BITS+3:0]     fade_full [3];

   assign xn = next_cell(mo.ci[0][7:0], period_ff);
   assign r8 = l3_ff + FX_ONE;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         off[k][0]    = $signed({3'b000, t3_ff[k]});
         off[k][1]    = $signed({3'b000, t3_ff[k]}) - FX_ONE;
         cube_full[k] = sq_ff[k] * t2_ff[k];
         fade_full[k] = cube_ff[k] * qs_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 1; s <= 9; s++) begin
            tag_ff[s].valid <= 1'b0;
         end
      end else if (adv) begin
         for (int s = 2; s <= 9; s++) begin
            tag_ff[s] <= tag_ff[s-1];
         end
         tag_ff[1] <= mo.tag;

         // stage 1: first hash level, t squared
         ha_ff[0] <= PERM_ROM[mo.ci[0][7:0]];
         ha_ff[1] <= PERM_ROM[xn];
         yi1_ff   <= mo.ci[1][7:0];
         yn1_ff   <= next_cell(mo.ci[1][7:0], period_ff);
         zi1_ff   <= mo.ci[2][7:0];
         zn1_ff   <= next_cell(mo.ci[2][7:0], period_ff);
         t1_ff    <= mo.fr;
         for (int k = 0; k < 3; k++) begin
            tt_ff[k] <= mo.fr[k] * mo.fr[k];
         end

         // stage 2: second hash level, fade polynomial
         for (int c = 0; c < 4; c++) begin
            hb_ff[c] <= PERM_ROM[8'(ha_ff[c % 2] + ((c / 2 == 1) ? yn1_ff : yi1_ff))];
         end
         zi2_ff <= zi1_ff;
         zn2_ff <= zn1_ff;
         t2_ff  <= t1_ff;
         for (int k = 0; k < 3; k++) begin
            sq_ff[k] <= tt_ff[k][2*FRAC_BITS-1:FRAC_BITS];
            q_ff[k]  <= QW'(6) * QW'(tt_ff[k]) + (QW'(10) << (2 * FRAC_BITS))
                        - ((QW'(t1_ff[k]) * QW'(15)) << FRAC_BITS);
         end

         // stage 3: corner hashes, cube
         for (int c = 0; c < 8; c++) begin
            hc_ff[c] <= PERM_ROM[8'(hb_ff[c % 4] + ((c / 4 == 1) ? zn2_ff : zi2_ff))];
         end
         t3_ff <= t2_ff;
         for (int k = 0; k < 3; k++) begin
            cube_ff[k] <= cube_full[k][2*FRAC_BITS-1:FRAC_BITS];
            qs_ff[k]   <= q_ff[k][QW-1:FRAC_BITS];
         end

         // stage 4: corner gradients, eased weights
         for (int c = 0; c < 8; c++) begin
            g_ff[c] <= grad(hc_ff[c], off[0][c % 2], off[1][(c / 2) % 2],
                            off[2][c / 4]);
         end
         for (int k = 0; k < 3; k++) begin
            fade_ff[k] <= NW'(fade_full[k] >> FRAC_BITS);
         end

         // stages 5 to 7: blend along x, y, z
         for (int c = 0; c < 4; c++) begin
            l1_ff[c] <= lerp(g_ff[2*c], g_ff[2*c+1], fade_ff[0]);
         end
         v5_ff <= fade_ff[1];
         w5_ff <= fade_ff[2];
         for (int c = 0; c < 2; c++) begin
            l2_ff[c] <= lerp(l1_ff[2*c], l1_ff[2*c+1], v5_ff);
         end
         w6_ff <= w5_ff;
         l3_ff <= lerp(l2_ff[0], l2_ff[1], w6_ff);

         // stage 8: map [-1,1] to [0,1], clamp
         if (r8 < 0) begin
            noise_ff <= '0;
         end else if (r8 > FX_TWO) begin
            noise_ff <= NW'(1 << FRAC_BITS);
         end else begin
            noise_ff <= r8[NW:1];
         end

         // stage 9: octave weighting
         noise9_ff <= noise_ff;
         prod_ff   <= noise_ff * tag_ff[8].amp;
      end
   end

   // -------------------------------------------------------------------------
   // Octave accumulation and bit-serial divide
   // -------------------------------------------------------------------------
   logic [TOT_W-1:0] total_ff;
   logic [TOT_W-1:0] total_in;
   logic [TOT_W-1:0] rem_ff;
   logic [SUM_W-1:0] dsor_ff;
   logic [DC_W-1:0]  dcnt_ff;
   logic [NW-1:0]    quo_ff;
   logic [TOT_W-1:0] dshift;
   logic             end_single;
   logic             end_oct;

   assign total_in   = total_ff + TOT_W'(prod_ff);
   assign dshift     = TOT_W'(dsor_ff) << dcnt_ff;
   assign end_single = adv && tag_ff[9].valid && !tag_ff[9].oct;
   assign end_oct    = adv && tag_ff[9].valid && tag_ff[9].oct;

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_done_ff <= 1'b0;
         total_ff    <= '0;
      end else begin
         if (end_oct) begin
            if (tag_ff[9].last) begin
               rem_ff      <= total_in;
               dsor_ff     <= amp_sum_ff;
               dcnt_ff     <= DC_W'(NW - 1);
               quo_ff      <= '0;
               div_busy_ff <= 1'b1;
               total_ff    <= '0;
            end else begin
               total_ff <= total_in;
            end
         end
         if (div_busy_ff && !div_done_ff) begin
            // one quotient bit per cycle, most significant first
            if (rem_ff >= dshift) begin
               rem_ff <= rem_ff - dshift;
               quo_ff <= {quo_ff[NW-2:0], 1'b1};
            end else begin
               quo_ff <= {quo_ff[NW-2:0], 1'b0};
            end
            dcnt_ff <= dcnt_ff - 1'b1;
            if (dcnt_ff == '0) begin
               div_done_ff <= 1'b1;
            end
         end
         if (div_done_ff && adv) begin
            div_busy_ff <= 1'b0;
            div_done_ff <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Response register
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= end_single || div_done_ff;
         if (end_single) begin
            rsp_tdata_ff <= to_q16(noise9_ff);
         end else if (div_done_ff) begin
            rsp_tdata_ff <= to_q16(quo_ff);
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // -------------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------------
   a_issue_in_octave: assert property (@(posedge clock) disable iff (reset)
      issue_ff |-> (mode_ff && oct_busy_ff))
      else $error("octave issue outside octave mode");

   a_start_issue: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && mode_ff) |=> issue_ff)
      else $error("octave transaction did not start issuing");

   a_no_single_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_busy_ff |-> !(tag_ff[9].valid && !tag_ff[9].oct))
      else $error("single item reached pipeline end during divide");

   a_divide_in_busy: assert property (@(posedge clock) disable iff (reset)
      div_busy_ff |-> (oct_busy_ff && !issue_ff))
      else $error("divider running outside octave transaction");

endmodule
`default_nettype wire
